[rtl/pdm_pkg.sv]
package pdm_pkg;

  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned PATTERN_W = 64;
  localparam int unsigned LEN_W     = 4;
  localparam int unsigned CFG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 1'd1;

  // Character that stands in for a deleted occurrence.
  localparam logic [CHAR_W-1:0] DASH_CHAR = 8'd45;

  typedef struct packed {
    logic [CHAR_W-1:0] chr;
    logic              valid;
    logic              last;
  } result_t;

endpackage

[rtl/pdm_cfg_regs.sv]
module pdm_cfg_regs #(
  parameter int unsigned PATTERN_MAX = 8,
  parameter int unsigned CNT_W       = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [pdm_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [pdm_pkg::PATTERN_W-1:0]  cfg_wdata,
  output logic [pdm_pkg::PATTERN_W-1:0]  pattern_r,
  output logic [CNT_W-1:0]               len_r
);

  logic [pdm_pkg::LEN_W-1:0] wr_len;
  logic [CNT_W-1:0]          len_nxt;

  // The stored length is already clamped into 1..PATTERN_MAX.
  assign wr_len = cfg_wdata[pdm_pkg::LEN_W-1:0];

  always_comb begin
    if (wr_len == '0) begin
      len_nxt = CNT_W'(1);
    end else if (32'(wr_len) > PATTERN_MAX) begin
      len_nxt = CNT_W'(PATTERN_MAX);
    end else begin
      len_nxt = CNT_W'(wr_len);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      len_r     <= CNT_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        pdm_pkg::CFG_PATTERN_BYTES:  pattern_r <= cfg_wdata;
        pdm_pkg::CFG_PATTERN_LENGTH: len_r     <= len_nxt;
        default: ;
      endcase
    end
  end

endmodule

[rtl/pdm_window.sv]
module pdm_window #(
  parameter int unsigned PATTERN_MAX = 8,
  parameter int unsigned CNT_W       = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [pdm_pkg::PATTERN_W-1:0] pattern,
  input  logic [CNT_W-1:0]              len,
  input  logic                          acc,
  input  logic [pdm_pkg::CHAR_W-1:0]    in_char,
  input  logic                          in_last,
  input  logic                          step_en,
  output logic                          busy,
  output logic                          emit,
  output pdm_pkg::result_t              res
);

  logic [pdm_pkg::CHAR_W-1:0] win_r   [PATTERN_MAX];
  logic [pdm_pkg::CHAR_W-1:0] win_nxt [PATTERN_MAX];
  logic [pdm_pkg::CHAR_W-1:0] w       [PATTERN_MAX];
  logic [CNT_W-1:0]           cnt_r, cnt_nxt, c;
  logic                       lastp_r, lastp_nxt, lastp;
  logic                       pend_r, pend_nxt, pend;
  logic                       resolve;
  logic                       match;

  // Further results are owed while the window is still being resolved after
  // a new character, or while an ended string is being flushed. Held
  // characters are only resolved once a new character has arrived.
  assign busy = pend_r || lastp_r;

  always_comb begin
    w     = win_r;
    c     = cnt_r;
    lastp = lastp_r;
    pend  = pend_r;
    if (acc) begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
        if (cnt_r == CNT_W'(i)) begin
          w[i] = in_char;
        end
      end
      c     = cnt_r + 1'b1;
      lastp = in_last;
      pend  = 1'b1;
    end

    match = 1'b1;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if ((CNT_W'(i) < len) && (w[i] != pattern[8*i +: 8])) begin
        match = 1'b0;
      end
    end

    resolve = pend && (c >= len);

    win_nxt = w;
    cnt_nxt = c;
    emit    = 1'b0;
    res.chr = w[0];
    if (step_en && (resolve || (lastp && (c != '0)))) begin
      emit = 1'b1;
      if (resolve && match) begin
        res.chr = pdm_pkg::DASH_CHAR;
        cnt_nxt = '0;
      end else begin
        for (int i = 0; i < PATTERN_MAX - 1; i++) begin
          win_nxt[i] = w[i+1];
        end
        cnt_nxt = c - 1'b1;
      end
    end

    pend_nxt  = pend && (cnt_nxt >= len);
    lastp_nxt = lastp && (cnt_nxt != '0);
    res.valid = 1'b1;
    res.last  = emit && lastp && (cnt_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      lastp_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      lastp_r <= lastp_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

endmodule

[rtl/pdm_out_reg.sv]
module pdm_out_reg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       emit,
  input  pdm_pkg::result_t           res,
  output logic                       free,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [pdm_pkg::CHAR_W-1:0] out_tdata,
  output logic                       out_tuser,
  output logic                       out_tlast
);

  logic             valid_r;
  pdm_pkg::result_t res_r;

  // The slot can take a new result when empty or when its result leaves now.
  assign free = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (emit) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = res_r.chr;
  assign out_tuser  = res_r.valid;
  assign out_tlast  = res_r.last;

endmodule

[rtl/pattern_delete_marker_filter.sv]
// Channel   Direction  Payload                                Request when
// in_       slave      tdata = in_char, tlast = in_last       tvalid & tready
// out_      master     tdata = out_char, tuser = out_valid,   tvalid & tready
//                      tlast = out_last
// cfg_      write      cfg_addr 0 pattern bytes, 1 length     cfg_we
//
// One input request is taken per cycle while in_tready is high and usually
// yields one result the next cycle. The window holds up to PATTERN_MAX
// characters; each cycle it resolves at most one result, so at the end of a
// string every character still held leaves as its own result, during which
// in_tready is low. A pattern length cut below the held count is resolved
// only when the next character arrives, at most one result per cycle, with
// in_tready low. Reset is synchronous and active low; it empties the window
// and sets the pattern length to 1. The output register stalls the window
// when out_tready is low and the result slot is full.
module pattern_delete_marker_filter #(
  parameter int unsigned PATTERN_MAX = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input stream.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [pdm_pkg::CHAR_W-1:0]     in_tdata,   // [7:0] in_char
  input  logic                           in_tlast,   // in_last
  // Result stream.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [pdm_pkg::CHAR_W-1:0]     out_tdata,  // [7:0] out_char
  output logic                           out_tuser,  // [0] out_valid
  output logic                           out_tlast,  // out_last
  // Configuration writes.
  input  logic                           cfg_we,
  input  logic [pdm_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [pdm_pkg::PATTERN_W-1:0]  cfg_wdata
);

  // The count must hold PATTERN_MAX itself.
  localparam int unsigned CNT_W = $clog2(PATTERN_MAX + 1);

  logic [pdm_pkg::PATTERN_W-1:0] pattern;
  logic [CNT_W-1:0]              len;
  logic                          free;
  logic                          busy;
  logic                          acc;
  logic                          emit;
  pdm_pkg::result_t              res;

  // A new character enters only when the window owes no further results and
  // the result slot can take whatever this character produces.
  assign in_tready = free && !busy;
  assign acc       = in_tvalid && in_tready;

  pdm_cfg_regs #(
    .PATTERN_MAX (PATTERN_MAX),
    .CNT_W       (CNT_W)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .pattern_r (pattern),
    .len_r     (len)
  );

  pdm_window #(
    .PATTERN_MAX (PATTERN_MAX),
    .CNT_W       (CNT_W)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .pattern (pattern),
    .len     (len),
    .acc     (acc),
    .in_char (in_tdata),
    .in_last (in_tlast),
    .step_en (free),
    .busy    (busy),
    .emit    (emit),
    .res     (res)
  );

  pdm_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .emit       (emit),
    .res        (res),
    .free       (free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

[bench/pattern_delete_marker_filter_test.sv]
module pattern_delete_marker_filter_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PATTERN_MAX   = 8;
  // Enough cycles for the block to drain a full window after the last result.
  localparam int SETTLE_CYCLES = PATTERN_MAX + 4;
  localparam int RESET_CYCLES  = 12;
  localparam int PHASE_CHARS   = 40;
  localparam int REPORT_LIMIT  = 10;

  localparam pdm_pkg::result_t NO_RESULT = '0;

  // Kinds of row in the directed table. A checked row carries a request whose
  // single result is typed into the table rather than taken from the predictor.
  typedef enum logic [1:0] {
    ROW_SET_PATTERN,
    ROW_SET_LENGTH,
    ROW_CHAR,
    ROW_CHECKED
  } row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic [63:0]      value;
    logic             last;
    pdm_pkg::result_t want;
  } row_t;

  logic                          clk        = 1'b0;
  logic                          rst_n      = 1'b0;
  logic                          in_tvalid  = 1'b0;
  logic                          in_tready;
  logic [pdm_pkg::CHAR_W-1:0]    in_tdata   = '0;
  logic                          in_tlast   = 1'b0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [pdm_pkg::CHAR_W-1:0]    out_tdata;
  logic                          out_tuser;
  logic                          out_tlast;
  logic                          cfg_we     = 1'b0;
  logic [pdm_pkg::CFG_IDX_W-1:0] cfg_addr   = '0;
  logic [pdm_pkg::PATTERN_W-1:0] cfg_wdata  = '0;

  // Shadow copy of the registers and of the character window.
  logic [pdm_pkg::PATTERN_W-1:0] pat_bytes = '0;
  logic [pdm_pkg::LEN_W-1:0]     pat_len   = pdm_pkg::LEN_W'(1);
  logic [pdm_pkg::CHAR_W-1:0]    win_bytes [PATTERN_MAX];
  int                            win_count = 0;

  // Results still owed by the block, oldest first.
  pdm_pkg::result_t pending_results [$];

  int send_idle_pct  = 32;
  int recv_idle_pct  = 74;
  int failures       = 0;
  int results_seen   = 0;
  int chars_sent     = 0;
  int strings_closed = 0;
  int settings_used  = 0;

  // Directed table. After reset the pattern is a single zero byte, so a zero
  // character becomes a dash and anything else passes straight through.
  row_t directed_rows [32] = '{
    '{ROW_CHECKED,     64'h00, 1'b1, '{pdm_pkg::DASH_CHAR, 1'b1, 1'b1}},
    '{ROW_CHECKED,     64'hFF, 1'b1, '{8'hFF, 1'b1, 1'b1}},
    // Two-character pattern "ab" in a string with a false start and a tail.
    '{ROW_SET_PATTERN, 64'h6261, 1'b0, NO_RESULT},
    '{ROW_SET_LENGTH,  64'd2,  1'b0, NO_RESULT},
    '{ROW_CHAR,        64'h78, 1'b0, NO_RESULT},
    '{ROW_CHAR,        64'h61, 1'b0, NO_RESULT},
    '{ROW_CHAR,        64'h62, 1'b0, NO_RESULT},
    '{ROW_CHAR,        64'h61, 1'b0, NO_RESULT},
    '{ROW_CHAR,        64'h61, 1'b0, NO_RESULT},
    '{ROW_CHAR,        64'h62, 1'b0, NO_RESULT},
    '{ROW_CHAR,        64'h61, 1'b1, NO_RESULT},
    // Widest pattern of all ones: eight 0xFF characters collapse into one dash.
    '{ROW_SET_PATTERN, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, NO_RESULT},
    '{ROW_SET_LENGTH,  64'd8,  1'b0, NO_RESULT},
    '{ROW_CHAR,        64'hFF, 1'b0, NO_RESULT},
    '{ROW_CHAR,        64'hFF, 1'b0, NO_RESULT},
    '{ROW_CHAR,        64'hFF, 1'b0, NO_RESULT},
    '{ROW_CHAR,        64'hFF, 1'b0, NO_RESULT},
    '{ROW_CHAR,        64'hFF, 1'b0, NO_RESULT},
    '{ROW_CHAR,        64'hFF, 1'b0, NO_RESULT},
    '{ROW_CHAR,        64'hFF, 1'b0, NO_RESULT},
    '{ROW_CHECKED,     64'hFF, 1'b1, '{pdm_pkg::DASH_CHAR, 1'b1, 1'b1}},
    // Three characters held at length eight, then the length drops to zero
    // (treated as one) before the string ends; the window drains when the last char arrives.
    '{ROW_CHAR,        64'h71, 1'b0, NO_RESULT},
    '{ROW_CHAR,        64'h72, 1'b0, NO_RESULT},
    '{ROW_CHAR,        64'h73, 1'b0, NO_RESULT},
    '{ROW_SET_PATTERN, 64'h71, 1'b0, NO_RESULT},
    '{ROW_SET_LENGTH,  64'd0,  1'b0, NO_RESULT},
    '{ROW_CHAR,        64'h74, 1'b1, NO_RESULT},
    // Length above the window size acts as eight; a short string is flushed.
    '{ROW_SET_PATTERN, 64'h0,  1'b0, NO_RESULT},
    '{ROW_SET_LENGTH,  64'd15, 1'b0, NO_RESULT},
    '{ROW_CHAR,        64'h00, 1'b0, NO_RESULT},
    '{ROW_CHAR,        64'h01, 1'b0, NO_RESULT},
    '{ROW_CHAR,        64'h00, 1'b1, NO_RESULT}
  };

  pattern_delete_marker_filter #(
    .PATTERN_MAX(PATTERN_MAX)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // The receiver decides afresh every cycle whether to take a result.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  function automatic void note_failure(input string what);
    failures++;
    if (failures <= REPORT_LIMIT) begin
      $display("ERROR at %0t: %s", $realtime, what);
    end
  endfunction

  // Compare every accepted result with the oldest one still owed.
  always @(posedge clk) begin
    pdm_pkg::result_t owed;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected result char=%02h valid=%0b last=%0b",
                               out_tdata, out_tuser, out_tlast));
      end else begin
        owed = pending_results.pop_front();
        results_seen++;
        if (out_tdata !== owed.chr || out_tuser !== owed.valid ||
            out_tlast !== owed.last) begin
          note_failure($sformatf(
            "result %0d: expected char=%02h valid=%0b last=%0b, got %02h %0b %0b",
            results_seen, owed.chr, owed.valid, owed.last,
            out_tdata, out_tuser, out_tlast));
        end
      end
    end
  end

  function automatic int eff_length();
    if (pat_len == 0) return 1;
    if (pat_len > PATTERN_MAX) return PATTERN_MAX;
    return int'(pat_len);
  endfunction

  // Push one character into the shadow window and queue the results it
  // causes. Returns how many results were queued.
  function automatic int replace_pattern(input logic [pdm_pkg::CHAR_W-1:0] chr,
                                         input logic last);
    pdm_pkg::result_t step [PATTERN_MAX+1];
    int               len;
    int               n;
    bit               hit;
    len = eff_length();
    n   = 0;
    if (win_count >= PATTERN_MAX) win_count = PATTERN_MAX - 1;
    win_bytes[win_count] = chr;
    win_count++;
    // The window is resolved for as long as it holds a full pattern's worth,
    // which matters when the length was cut while characters were held.
    while (win_count >= len) begin
      hit = 1'b1;
      for (int i = 0; i < len; i++) begin
        if (win_bytes[i] !== pat_bytes[8*i +: 8]) hit = 1'b0;
      end
      if (hit) begin
        step[n]   = '{pdm_pkg::DASH_CHAR, 1'b1, 1'b0};
        win_count = 0;
      end else begin
        step[n] = '{win_bytes[0], 1'b1, 1'b0};
        for (int i = 0; i < PATTERN_MAX - 1; i++) win_bytes[i] = win_bytes[i+1];
        win_count--;
      end
      n++;
    end
    if (last) begin
      for (int i = 0; i < win_count; i++) begin
        step[n] = '{win_bytes[i], 1'b1, 1'b0};
        n++;
      end
      win_count = 0;
      // A string end that yields no character still produces a bare marker.
      if (n == 0) begin
        step[n] = NO_RESULT;
        n++;
      end
      step[n-1].last = 1'b1;
    end
    for (int i = 0; i < n; i++) pending_results.push_back(step[i]);
    return n;
  endfunction

  // Present one character, with random idle cycles in front of it, and return
  // at the edge where the request is taken.
  task automatic offer_char(input logic [pdm_pkg::CHAR_W-1:0] chr, input logic last);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= chr;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    chars_sent++;
    if (last) strings_closed++;
  endtask

  task automatic send_char(input logic [pdm_pkg::CHAR_W-1:0] chr, input logic last);
    offer_char(chr, last);
    void'(replace_pattern(chr, last));
  endtask

  // Registers only change once every owed result is out and the block has had
  // time to finish with characters that caused none.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [pdm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [63:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == pdm_pkg::CFG_PATTERN_BYTES) begin
      pat_bytes = value;
    end else begin
      pat_len = value[pdm_pkg::LEN_W-1:0];
    end
  endtask

  // Random setting: mostly short patterns, sometimes a repeated byte so that
  // occurrences overlap, and now and then a length of zero or above eight.
  task automatic pick_setting();
    logic [63:0]                pat;
    logic [pdm_pkg::LEN_W-1:0]  len;
    logic [pdm_pkg::CHAR_W-1:0] fill;
    fill = pdm_pkg::CHAR_W'($urandom);
    if ($urandom_range(0, 4) == 0) begin
      pat = {8{fill}};
    end else begin
      pat = {$urandom, $urandom};
    end
    case ($urandom_range(0, 9))
      0: begin
        len = '0;
      end
      1: begin
        len = pdm_pkg::LEN_W'($urandom_range(PATTERN_MAX + 1, 15));
      end
      2: begin
        len = pdm_pkg::LEN_W'(PATTERN_MAX);
      end
      3: begin
        len = pdm_pkg::LEN_W'(1);
      end
      default: begin
        len = pdm_pkg::LEN_W'($urandom_range(2, 4));
      end
    endcase
    settle();
    write_reg(pdm_pkg::CFG_PATTERN_BYTES, pat);
    write_reg(pdm_pkg::CFG_PATTERN_LENGTH, 64'(len));
    settings_used++;
  endtask

  // A string built mostly from the pattern: whole copies, copies with one bit
  // flipped, and loose pattern characters, with some unrelated bytes mixed in.
  // An open string is left without its end so that characters stay held
  // across the next register change.
  task automatic send_string(input bit open);
    logic [pdm_pkg::CHAR_W-1:0] text [$];
    logic [pdm_pkg::CHAR_W-1:0] b;
    int                         n;
    int                         len;
    int                         r;
    int                         spoil;
    int                         pick;
    n   = $urandom_range(1, 12);
    len = eff_length();
    while (text.size() < n) begin
      r = $urandom_range(0, 9);
      if (r < 4) begin
        spoil = (r == 0) ? $urandom_range(0, len - 1) : -1;
        for (int i = 0; i < len; i++) begin
          b = pat_bytes[8*i +: 8];
          if (i == spoil) b = b ^ (8'h01 << $urandom_range(0, 7));
          text.push_back(b);
        end
      end else if (r < 8) begin
        pick = $urandom_range(0, len - 1);
        text.push_back(pat_bytes[8*pick +: 8]);
      end else begin
        text.push_back(pdm_pkg::CHAR_W'($urandom));
      end
    end
    foreach (text[i]) begin
      send_char(text[i], !open && (i == text.size() - 1));
    end
  endtask

  initial begin
    int phase_start;
    int n;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, under the first idling scheme.
    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_SET_PATTERN: begin
          settle();
          write_reg(pdm_pkg::CFG_PATTERN_BYTES, directed_rows[i].value);
        end
        ROW_SET_LENGTH: begin
          settle();
          write_reg(pdm_pkg::CFG_PATTERN_LENGTH, directed_rows[i].value);
        end
        default: begin
          offer_char(directed_rows[i].value[pdm_pkg::CHAR_W-1:0], directed_rows[i].last);
          n = replace_pattern(directed_rows[i].value[pdm_pkg::CHAR_W-1:0],
                              directed_rows[i].last);
          // The typed result stands in for the predicted one; the predictor
          // still runs so that its window stays in step.
          if (directed_rows[i].kind == ROW_CHECKED) begin
            repeat (n) void'(pending_results.pop_back());
            pending_results.push_back(directed_rows[i].want);
          end
        end
      endcase
    end

    // Random part in three phases: sender idles less than the receiver, then
    // the reverse, then both run flat out.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 32;
          recv_idle_pct = 74;
        end
        1: begin
          send_idle_pct = 74;
          recv_idle_pct = 32;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      phase_start = chars_sent;
      while (chars_sent - phase_start < PHASE_CHARS) begin
        pick_setting();
        repeat ($urandom_range(2, 4)) send_string($urandom_range(0, 4) == 0);
      end
    end

    // Close whatever string is still open so the window is flushed.
    send_char(pdm_pkg::CHAR_W'($urandom), 1'b1);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d characters in %0d finished strings over %0d random settings,",
             chars_sent, strings_closed, settings_used);
    $display("with %0d results compared and %0d failures.", results_seen, failures);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, even with every request
  // causing a full window of results behind a mostly stalled receiver.
  initial begin
    #2_000_000;
    $display("ERROR: run did not finish in time, %0d results still owed",
             pending_results.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

[pattern_delete_marker_filter.f]
rtl/pdm_pkg.sv
rtl/pdm_cfg_regs.sv
rtl/pdm_window.sv
rtl/pdm_out_reg.sv
rtl/pattern_delete_marker_filter.sv
bench/pattern_delete_marker_filter_test.sv
